// File: hdl/ple_pkg.sv
`default_nettype none
package ple_pkg;

  localparam int OP_W      = 3;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;
  localparam int ST_W      = 2;

  localparam int CAPACITY_DEF = 64;

  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLACE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [VAL_W-1:0] value_t;

endpackage
`default_nettype wire

// File: hdl/positional_list_engine.sv
`default_nettype none
// Ordered list of signed 32-bit entries held in one synchronous RAM of
// CAPACITY words. An item (in_op, in_position, in_value) is taken at a rising
// edge with start high and busy low; busy stays high while the item works.
// Exactly one result per item appears on out_value, out_count and out_status
// for a single cycle, marked by out_strobe. The receiver cannot hold results
// off, and a new item may be started in the same cycle that a result shows.
// Each item moves through the single RAM port pair, which moves one entry
// per cycle:
//   replace, clear, unused codes, any range or full error: never busy
//   retrieve: one RAM read
//   delete: read, then shift the tail down
//   insert: shift the tail up, then write the value;
//           an append writes the value with no shift
// Reset clears the entry count and the control state; the RAM contents are
// not cleared and entries at or beyond the count are never read.
// out_count is the entry count after the item, truncated to 7 bits.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [ple_pkg::OP_W-1:0]         in_op,
  input  wire  [ple_pkg::POS_W-1:0]        in_position,
  input  wire  signed [ple_pkg::VAL_W-1:0] in_value,
  output logic                             out_strobe,
  output logic signed [ple_pkg::VAL_W-1:0] out_value,
  output logic [ple_pkg::CNT_OUT_W-1:0]    out_count,
  output logic [ple_pkg::ST_W-1:0]         out_status
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
  localparam int WIDE_W = CMP_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_DFIRST = 3'd2;
  localparam logic [2:0] S_DSHIFT = 3'd3;
  localparam logic [2:0] S_ISHIFT = 3'd4;
  localparam logic [2:0] S_ILAST  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [ADDR_W-1:0]       idx_r, idx_nxt;
  logic [ADDR_W-1:0]       pos_r, pos_nxt;
  ple_pkg::value_t         val_r, val_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  ple_pkg::value_t         out_value_r, out_value_nxt;
  logic [ple_pkg::ST_W-1:0] out_status_r, out_status_nxt;

  ple_pkg::value_t         mem [CAPACITY];
  ple_pkg::value_t         rd_data_r;
  logic                    we, re;
  logic [ADDR_W-1:0]       wa, ra;
  ple_pkg::value_t         wd;

  logic [CMP_W-1:0]        pos_ext, cnt_ext, cnt_m1;
  logic [ADDR_W-1:0]       pos_a, idx_p1, idx_p2, idx_m1, idx_m2;
  logic [WIDE_W-1:0]       idx_w_p1, idx_w_p2, cnt_w;

  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign cnt_m1   = cnt_ext - CMP_W'(1);
  assign pos_a    = pos_ext[ADDR_W-1:0];
  assign idx_p1   = idx_r + ADDR_W'(1);
  assign idx_p2   = idx_r + ADDR_W'(2);
  assign idx_m1   = idx_r - ADDR_W'(1);
  assign idx_m2   = idx_r - ADDR_W'(2);
  assign cnt_w    = WIDE_W'(count_r);
  assign idx_w_p1 = WIDE_W'(idx_r) + WIDE_W'(1);
  assign idx_w_p2 = WIDE_W'(idx_r) + WIDE_W'(2);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    we             = 1'b0;
    re             = 1'b0;
    wa             = idx_r;
    wd             = rd_data_r;
    ra             = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pos_nxt        = pos_a;
          val_nxt        = in_value;
          out_value_nxt  = '0;
          out_status_nxt = ple_pkg::ST_OK;
          out_strobe_nxt = 1'b1;
          unique case (in_op)
            ple_pkg::OP_INSERT: begin
              priority if (pos_ext > cnt_ext) begin
                out_status_nxt = ple_pkg::ST_RANGE;
              end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                out_status_nxt = ple_pkg::ST_FULL;
              end else if (pos_ext == cnt_ext) begin
                // append: nothing to move
                we        = 1'b1;
                wa        = pos_a;
                wd        = in_value;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                out_strobe_nxt = 1'b0;
                re             = 1'b1;
                ra             = cnt_m1[ADDR_W-1:0];
                idx_nxt        = cnt_ext[ADDR_W-1:0];
                state_nxt      = S_ISHIFT;
              end
            end
            ple_pkg::OP_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ple_pkg::ST_RANGE;
              end else begin
                out_strobe_nxt = 1'b0;
                re             = 1'b1;
                ra             = pos_a;
                idx_nxt        = pos_a;
                state_nxt      = S_DFIRST;
              end
            end
            ple_pkg::OP_RETRIEVE: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ple_pkg::ST_RANGE;
              end else begin
                out_strobe_nxt = 1'b0;
                re             = 1'b1;
                ra             = pos_a;
                state_nxt      = S_READ;
              end
            end
            ple_pkg::OP_REPLACE: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ple_pkg::ST_RANGE;
              end else begin
                we = 1'b1;
                wa = pos_a;
                wd = in_value;
              end
            end
            ple_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        out_value_nxt  = rd_data_r;
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DFIRST: begin
        // hold the removed entry in the output register until the shift ends
        out_value_nxt = rd_data_r;
        if (idx_w_p1 < cnt_w) begin
          re        = 1'b1;
          ra        = idx_p1;
          state_nxt = S_DSHIFT;
        end else begin
          count_nxt      = count_r - CNT_W'(1);
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DSHIFT: begin
        we      = 1'b1;
        wa      = idx_r;
        wd      = rd_data_r;
        idx_nxt = idx_p1;
        if (idx_w_p2 < cnt_w) begin
          re = 1'b1;
          ra = idx_p2;
        end else begin
          count_nxt      = count_r - CNT_W'(1);
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ISHIFT: begin
        we = 1'b1;
        wa = idx_r;
        wd = rd_data_r;
        if (idx_m1 > pos_r) begin
          re      = 1'b1;
          ra      = idx_m2;
          idx_nxt = idx_m1;
        end else begin
          state_nxt = S_ILAST;
        end
      end
      S_ILAST: begin
        we             = 1'b1;
        wa             = pos_r;
        wd             = val_r;
        count_nxt      = count_r + CNT_W'(1);
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = cnt_ext[ple_pkg::CNT_OUT_W-1:0];

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == S_IDLE))
    else $error("result strobe while item still in progress");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe_r || busy))
    else $error("accepted item neither finished nor in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r == ple_pkg::ST_FULL) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(start && !busy) && $past(busy)) |-> $stable(count_r))
    else $error("entry count moved in the middle of a shift");

endmodule
`default_nettype wire

// File: verif/positional_list_engine_tb.sv
module positional_list_engine_tb;

  localparam int LIST_DEPTH = ple_pkg::CAPACITY_DEF;
  localparam int OP_LAST    = (1 << ple_pkg::OP_W) - 1;

  typedef logic [ple_pkg::OP_W-1:0]  op_t;
  typedef logic [ple_pkg::POS_W-1:0] pos_t;

  localparam pos_t POS_MAX = '1;

  typedef struct {
    ple_pkg::value_t                value;
    logic [ple_pkg::CNT_OUT_W-1:0]  count;
    logic [ple_pkg::ST_W-1:0]       status;
  } list_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  op_t                           in_op = '0;
  pos_t                          in_position = '0;
  ple_pkg::value_t               in_value = '0;
  logic                          busy;
  logic                          out_strobe;
  ple_pkg::value_t               out_value;
  logic [ple_pkg::CNT_OUT_W-1:0] out_count;
  logic [ple_pkg::ST_W-1:0]      out_status;

  // shadow copy of the list, updated when an item is taken
  ple_pkg::value_t      shadow_entries [LIST_DEPTH];
  int unsigned          shadow_count = 0;
  list_result_t         pending_results [$];

  int unsigned          fault_count = 0;
  int unsigned          items_taken = 0;
  int unsigned          status_tally [3] = '{0, 0, 0};
  int unsigned          peak_depth = 0;
  int unsigned          burst_left = 0;

  positional_list_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_op      (in_op),
    .in_position(in_position),
    .in_value   (in_value),
    .out_strobe (out_strobe),
    .out_value  (out_value),
    .out_count  (out_count),
    .out_status (out_status)
  );

  always #5 clk = ~clk;

  task automatic apply_list_item(input op_t op, input pos_t pos,
                                 input ple_pkg::value_t val, output list_result_t res);
    int unsigned p;
    int unsigned i;
    p = pos;
    res.value  = '0;
    res.status = ple_pkg::ST_OK;
    case (op)
      ple_pkg::OP_INSERT: begin
        if (p > shadow_count) begin
          res.status = ple_pkg::ST_RANGE;
        end else if (shadow_count >= LIST_DEPTH) begin
          res.status = ple_pkg::ST_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p] = val;
          shadow_count++;
        end
      end
      ple_pkg::OP_DELETE: begin
        if (p >= shadow_count) begin
          res.status = ple_pkg::ST_RANGE;
        end else begin
          res.value = shadow_entries[p];
          for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      ple_pkg::OP_RETRIEVE: begin
        if (p >= shadow_count) res.status = ple_pkg::ST_RANGE;
        else res.value = shadow_entries[p];
      end
      ple_pkg::OP_REPLACE: begin
        if (p >= shadow_count) res.status = ple_pkg::ST_RANGE;
        else shadow_entries[p] = val;
      end
      ple_pkg::OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.count = shadow_count[ple_pkg::CNT_OUT_W-1:0];
    status_tally[res.status]++;
    if (shadow_count > peak_depth) peak_depth = shadow_count;
  endtask

  // hold start until the item is taken, then maybe open a gap
  task automatic send_item(input op_t op, input pos_t pos, input ple_pkg::value_t val);
    list_result_t res;
    start       <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_list_item(op, pos, val, res);
    pending_results.push_back(res);
    items_taken++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain_results();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    burst_left = $urandom_range(0, 8);
  endtask

  function automatic ple_pkg::value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      4:       return $signed($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  // mostly legal positions, some on the boundary, a few anywhere
  function automatic pos_t pick_position(input op_t op);
    int unsigned r;
    int unsigned top;
    r = $urandom_range(0, 99);
    if (op == ple_pkg::OP_INSERT) top = shadow_count;
    else top = (shadow_count == 0) ? 0 : shadow_count - 1;
    if (r < 85) return pos_t'($urandom_range(0, top));
    if (r < 95) return pos_t'(shadow_count + $urandom_range(0, 1));
    return pos_t'($urandom_range(0, POS_MAX));
  endfunction

  task automatic test_directed();
    int c;
    // empty list: retrieve, delete, replace and inserts past the end must flag range
    send_item(ple_pkg::OP_RETRIEVE, 0, 0);
    send_item(ple_pkg::OP_DELETE, 0, 0);
    send_item(ple_pkg::OP_REPLACE, 0, 32'sh1234_5678);
    send_item(ple_pkg::OP_INSERT, 1, 5);
    send_item(ple_pkg::OP_INSERT, POS_MAX, 5);
    send_item(ple_pkg::OP_INSERT, 0, 32'sh7FFF_FFFF);
    send_item(ple_pkg::OP_INSERT, 1, 32'sh8000_0000);
    send_item(ple_pkg::OP_INSERT, 0, 0);
    send_item(ple_pkg::OP_INSERT, 2, -1);
    send_item(ple_pkg::OP_RETRIEVE, 3, 0);
    send_item(ple_pkg::OP_RETRIEVE, 1, 0);
    send_item(ple_pkg::OP_RETRIEVE, 4, 0);
    send_item(ple_pkg::OP_REPLACE, 2, 32'sh5A5A_A5A5);
    send_item(ple_pkg::OP_REPLACE, POS_MAX, -1);
    send_item(ple_pkg::OP_RETRIEVE, 2, 0);
    send_item(ple_pkg::OP_DELETE, 1, 0);
    send_item(ple_pkg::OP_DELETE, 2, 0);
    send_item(ple_pkg::OP_DELETE, 4, 0);
    for (c = ple_pkg::OP_CLEAR + 1; c <= OP_LAST; c++)
      send_item(c[ple_pkg::OP_W-1:0], POS_MAX, -1);
    send_item(ple_pkg::OP_CLEAR, 0, 0);
    send_item(ple_pkg::OP_RETRIEVE, 0, 0);
    send_item(ple_pkg::OP_INSERT, 0, 32'sh0BAD_F00D);
    send_item(ple_pkg::OP_RETRIEVE, 0, 0);
  endtask

  task automatic test_fill_and_drain();
    while (shadow_count < LIST_DEPTH)
      send_item(ple_pkg::OP_INSERT, pos_t'($urandom_range(0, shadow_count)), pick_value());
    send_item(ple_pkg::OP_INSERT, pos_t'(LIST_DEPTH + 1), pick_value());
    send_item(ple_pkg::OP_INSERT, 0, pick_value());
    send_item(ple_pkg::OP_INSERT, pos_t'(LIST_DEPTH), pick_value());
    send_item(ple_pkg::OP_RETRIEVE, pos_t'(LIST_DEPTH - 1), 0);
    send_item(ple_pkg::OP_DELETE, 0, 0);
    send_item(ple_pkg::OP_INSERT, 0, pick_value());
    send_item(ple_pkg::OP_REPLACE, pos_t'(LIST_DEPTH - 1), pick_value());
    send_item(ple_pkg::OP_DELETE, pos_t'(LIST_DEPTH - 1), 0);
    drain_results();
    while (shadow_count > 0)
      send_item(ple_pkg::OP_DELETE, pos_t'($urandom_range(0, shadow_count - 1)), 0);
  endtask

  task automatic test_random_mix(input int n_items, input int insert_pct, input int delete_pct);
    int k;
    int unsigned r;
    op_t op;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        op = ple_pkg::OP_INSERT;
      end else if (r < insert_pct + delete_pct) begin
        op = ple_pkg::OP_DELETE;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) op = ple_pkg::OP_CLEAR;
        else if (r < 6) op = op_t'($urandom_range(ple_pkg::OP_CLEAR + 1, OP_LAST));
        else if (r < 53) op = ple_pkg::OP_RETRIEVE;
        else op = ple_pkg::OP_REPLACE;
      end
      send_item(op, pick_position(op), pick_value());
    end
  endtask

  always @(posedge clk) begin : check_result
    list_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d count %0d status %0d",
               out_value, out_count, out_status);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value);
          fault_count++;
        end
        if (out_count !== want.count) begin
          $error("out_count: expected %0d, got %0d", want.count, out_count);
          fault_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("positional_list_engine_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain_results();
    test_fill_and_drain();
    test_random_mix(500, 35, 25);
    drain_results();
    test_random_mix(300, 70, 15);
    test_random_mix(250, 15, 60);

    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    waited = 0;
    while (pending_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (LIST_DEPTH + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fault_count++;
    end

    $display("%0d items taken: %0d ok, %0d out of range, %0d list full",
             items_taken, status_tally[ple_pkg::ST_OK], status_tally[ple_pkg::ST_RANGE],
             status_tally[ple_pkg::ST_FULL]);
    $display("list depth reached %0d of %0d, %0d field mismatches",
             peak_depth, LIST_DEPTH, fault_count);
    if (fault_count == 0) begin
      $display("positional_list_engine_tb: done, clean");
    end else begin
      $display("positional_list_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
